FILE: rtl/efw_pkg.sv
// ----------------------------------------------------------------------------
// efw_pkg
// Shared codes, field widths and the match rule of the event flag wait/set unit.
// ----------------------------------------------------------------------------
`default_nettype none

package efw_pkg;

  // fixed field widths and default table sizes
  localparam int unsigned FLAG_W       = 32;
  localparam int unsigned TID_W        = 8;
  localparam int unsigned DEF_FLAGS    = 16;
  localparam int unsigned DEF_WAITERS  = 16;

  // command codes
  typedef enum logic [2:0] {
    CMD_CREATE = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_SET    = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_WAIT   = 3'd4,
    CMD_POLL   = 3'd5,
    CMD_STATUS = 3'd6,
    CMD_NONE   = 3'd7
  } cmd_e;

  // status codes
  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_UNKNOWN  = 4'd1,
    ST_NO_SLOT  = 4'd2,
    ST_ZERO_PAT = 4'd3,
    ST_MULTI    = 4'd4,
    ST_COND     = 4'd5,
    ST_DELETED  = 4'd6,
    ST_QUEUED   = 4'd7,
    ST_FULL     = 4'd8
  } status_e;

  // one result item
  typedef struct packed {
    logic              kind;
    status_e           status;
    logic [3:0]        flag;
    logic [TID_W-1:0]  thread;
    logic [FLAG_W-1:0] bits;
    logic [FLAG_W-1:0] init;
    logic [4:0]        waiters;
    logic              multi;
    logic [FLAG_W-1:0] option;
    logic              last;
  } result_t;

  // any-bit or all-bit match of a wait pattern
  function automatic logic flag_match(logic [FLAG_W-1:0] flag, logic [FLAG_W-1:0] pat,
                                      logic any);
    logic [FLAG_W-1:0] hit;
    hit = flag & pat;
    return any ? (hit != '0) : (hit == pat);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/event_flag_wait_set_unit.sv
// ----------------------------------------------------------------------------
// event_flag_wait_set_unit
// Event flag bank with a shared, arrival-ordered table of waiting threads.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_stall_o    | command .. thread_id
//  out     | output    | out_valid_o / out_stall_i  | kind .. last
//
//  Every command passes capture, flag memory read and execute in turn.
//  A delete or a nonzero set then streams the waiter table, one row per
//  unstalled cycle through the single read port, compacting kept rows in place.
//  Reset clears the in-use bits, the table fill and the output valid bit.
//  A stalled output register holds the sequencer until it frees.
`default_nettype none

module event_flag_wait_set_unit
  import efw_pkg::*;
#(
  parameter int unsigned NUM_FLAGS   = DEF_FLAGS,
  parameter int unsigned NUM_WAITERS = DEF_WAITERS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [2:0]        command_i,
  input  wire logic [3:0]        flag_id_i,
  input  wire logic [FLAG_W-1:0] bits_i,
  input  wire logic              multi_attr_i,
  input  wire logic [FLAG_W-1:0] option_word_i,
  input  wire logic              wait_or_i,
  input  wire logic              wait_clear_i,
  input  wire logic [TID_W-1:0]  thread_id_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   kind_o,
  output logic [3:0]             status_o,
  output logic [3:0]             result_flag_o,
  output logic [TID_W-1:0]       woken_thread_o,
  output logic [FLAG_W-1:0]      bits_out_o,
  output logic [FLAG_W-1:0]      initial_bits_out_o,
  output logic [4:0]             waiters_out_o,
  output logic                   multi_out_o,
  output logic [FLAG_W-1:0]      option_out_o,
  output logic                   last_o
);

  localparam int unsigned FIW = (NUM_FLAGS > 1) ? $clog2(NUM_FLAGS) : 1;
  localparam int unsigned WAW = (NUM_WAITERS > 1) ? $clog2(NUM_WAITERS) : 1;
  localparam int unsigned CW  = $clog2(NUM_WAITERS + 1);

  typedef struct packed {
    logic [FLAG_W-1:0] pattern;
    logic [FLAG_W-1:0] init;
    logic              multi;
    logic [FLAG_W-1:0] option;
    logic [CW-1:0]     waiters;
  } flag_t;

  typedef struct packed {
    logic [FIW-1:0]    flag;
    logic [FLAG_W-1:0] pattern;
    logic              any;
    logic              clr;
    logic [TID_W-1:0]  thread;
  } waiter_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EXEC = 4'b0100,
    S_SCAN = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // captured item
  cmd_e              cmd_q;
  logic [3:0]        fid_q;
  logic [FLAG_W-1:0] bits_q;
  logic              multi_q, any_q, clr_q;
  logic [FLAG_W-1:0] option_q;
  logic [TID_W-1:0]  tid_q;

  // control state
  logic [NUM_FLAGS-1:0] in_use_q;
  logic [CW-1:0]        fill_q, fill_d;
  logic [CW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]        p_q, p_d;
  logic [CW-1:0]        w_q, w_d;
  logic [FLAG_W-1:0]    pat_q, pat_d;
  logic [CW-1:0]        cnt_q, cnt_d;

  // memories
  flag_t   flag_mem [NUM_FLAGS];
  waiter_t wt_mem   [NUM_WAITERS];
  flag_t   flag_rd_q;
  waiter_t wt_rd_q;

  logic           flag_we, wt_we, rd_en, use_set, use_clr;
  logic [FIW-1:0] flag_wa;
  flag_t          flag_wd;
  logic [WAW-1:0] wt_wa;
  waiter_t        wt_wd;

  // output register
  logic    out_vld_q, load, out_free;
  result_t res_d, res_q;

  // addressed slot
  logic           fid_in_range, known;
  logic [FIW-1:0] fx;
  logic [FIW-1:0] free_idx;
  logic           free_found;

  assign fid_in_range = 32'(fid_q) < NUM_FLAGS;
  assign fx           = fid_in_range ? FIW'(fid_q) : '0;
  assign known        = fid_in_range && in_use_q[fx];
  assign out_free     = !out_vld_q || !out_stall_i;
  assign in_stall_o   = (state_q != S_IDLE);

  // lowest free flag slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = NUM_FLAGS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_idx   = FIW'(i);
        free_found = 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    load     = 1'b0;
    res_d    = '0;
    res_d.last   = 1'b1;
    res_d.status = ST_OK;
    flag_we  = 1'b0;
    flag_wa  = fx;
    flag_wd  = flag_rd_q;
    wt_we    = 1'b0;
    wt_wa    = '0;
    wt_wd    = wt_rd_q;
    rd_en    = 1'b0;
    use_set  = 1'b0;
    use_clr  = 1'b0;
    pat_d    = pat_q;
    cnt_d    = cnt_q;
    p_d      = p_q;
    w_d      = w_q;
    fill_d   = fill_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_READ;
          p_d     = '0;
          w_d     = '0;
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          load       = 1'b1;
          res_d.flag = fid_q;
          state_d    = S_IDLE;
          if (cmd_q == CMD_CREATE) begin
            if (free_found) begin
              use_set         = 1'b1;
              flag_we         = 1'b1;
              flag_wa         = free_idx;
              flag_wd.pattern = bits_q;
              flag_wd.init    = bits_q;
              flag_wd.multi   = multi_q;
              flag_wd.option  = option_q;
              flag_wd.waiters = '0;
              res_d.flag      = 4'(free_idx);
            end else begin
              res_d.status = ST_NO_SLOT;
              res_d.flag   = '0;
            end
          end else if (cmd_q == CMD_NONE) begin
            res_d.flag = '0;
          end else if ((cmd_q == CMD_WAIT || cmd_q == CMD_POLL) && bits_q == '0) begin
            res_d.status = ST_ZERO_PAT;
          end else if (!known) begin
            res_d.status = ST_UNKNOWN;
          end else begin
            res_d.flag = 4'(fx);
            case (cmd_q)
              CMD_DELETE: begin
                load    = 1'b0;
                state_d = S_SCAN;
              end
              CMD_SET: begin
                if (bits_q != '0) begin
                  load    = 1'b0;
                  state_d = S_SCAN;
                  pat_d   = flag_rd_q.pattern | bits_q;
                  cnt_d   = flag_rd_q.waiters;
                end
              end
              CMD_CLEAR: begin
                flag_we         = 1'b1;
                flag_wd.pattern = flag_rd_q.pattern & bits_q;
              end
              CMD_WAIT, CMD_POLL: begin
                if (!flag_rd_q.multi && flag_rd_q.waiters != '0) begin
                  res_d.status = ST_MULTI;
                end else if (flag_match(flag_rd_q.pattern, bits_q, any_q)) begin
                  res_d.bits = flag_rd_q.pattern;
                  if (clr_q) begin
                    flag_we         = 1'b1;
                    flag_wd.pattern = '0;
                  end
                end else if (cmd_q == CMD_POLL) begin
                  res_d.status = ST_COND;
                end else if (32'(fill_q) >= NUM_WAITERS) begin
                  res_d.status = ST_FULL;
                end else begin
                  res_d.status    = ST_QUEUED;
                  wt_we           = 1'b1;
                  wt_wa           = WAW'(fill_q);
                  wt_wd.flag      = fx;
                  wt_wd.pattern   = bits_q;
                  wt_wd.any       = any_q;
                  wt_wd.clr       = clr_q;
                  wt_wd.thread    = tid_q;
                  fill_d          = fill_q + 1'b1;
                  flag_we         = 1'b1;
                  flag_wd.waiters = flag_rd_q.waiters + 1'b1;
                end
              end
              CMD_STATUS: begin
                res_d.bits    = flag_rd_q.pattern;
                res_d.init    = flag_rd_q.init;
                res_d.waiters = 5'(flag_rd_q.waiters);
                res_d.multi   = flag_rd_q.multi;
                res_d.option  = flag_rd_q.option;
              end
              default: begin
                res_d.flag = '0;
              end
            endcase
          end
        end
      end
      S_SCAN: begin
        res_d.flag = 4'(fx);
        if (p_q == fill_q) begin
          // end of table: write back and reply
          if (out_free) begin
            load    = 1'b1;
            fill_d  = w_q;
            state_d = S_IDLE;
            if (cmd_q == CMD_SET) begin
              flag_we         = 1'b1;
              flag_wd.pattern = pat_q;
              flag_wd.waiters = cnt_q;
            end else begin
              use_clr = 1'b1;
            end
          end
        end else if (out_free) begin
          // one row: wake it or keep it
          rd_en = 32'(rd_ptr_q) < NUM_WAITERS;
          p_d   = p_q + 1'b1;
          if (wt_rd_q.flag == fx &&
              (cmd_q == CMD_DELETE ||
               (pat_q != '0 && flag_match(pat_q, wt_rd_q.pattern, wt_rd_q.any)))) begin
            load         = 1'b1;
            res_d.kind   = 1'b1;
            res_d.last   = 1'b0;
            res_d.thread = wt_rd_q.thread;
            if (cmd_q == CMD_DELETE) begin
              res_d.status = ST_DELETED;
            end else begin
              res_d.bits = pat_q;
              if (wt_rd_q.clr) begin
                pat_d = '0;
              end
              if (cnt_q != '0) begin
                cnt_d = cnt_q - 1'b1;
              end
            end
          end else begin
            wt_we = 1'b1;
            wt_wa = WAW'(w_q);
            wt_wd = wt_rd_q;
            w_d   = w_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      in_use_q  <= '0;
      fill_q    <= '0;
      rd_ptr_q  <= '0;
      p_q       <= '0;
      w_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      p_q      <= p_d;
      w_q      <= w_d;
      rd_ptr_q <= (state_q == S_IDLE) ? '0 : rd_ptr_d;
      if (use_set) begin
        in_use_q[free_idx] <= 1'b1;
      end
      if (use_clr) begin
        in_use_q[fx] <= 1'b0;
      end
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // item capture and scan working copies
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_q    <= cmd_e'(command_i);
      fid_q    <= flag_id_i;
      bits_q   <= bits_i;
      multi_q  <= multi_attr_i;
      option_q <= option_word_i;
      any_q    <= wait_or_i;
      clr_q    <= wait_clear_i;
      tid_q    <= thread_id_i;
    end
    pat_q <= pat_d;
    cnt_q <= cnt_d;
    if (load) begin
      res_q <= res_d;
    end
  end

  // flag memory
  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[flag_wa] <= flag_wd;
    end
    flag_rd_q <= flag_mem[fx];
  end

  // waiter table memory
  always_ff @(posedge clk_i) begin
    if (wt_we) begin
      wt_mem[wt_wa] <= wt_wd;
    end
    if (rd_en) begin
      wt_rd_q <= wt_mem[WAW'(rd_ptr_q)];
    end
  end

  // result ports
  assign out_valid_o        = out_vld_q;
  assign kind_o             = res_q.kind;
  assign status_o           = res_q.status;
  assign result_flag_o      = res_q.flag;
  assign woken_thread_o     = res_q.thread;
  assign bits_out_o         = res_q.bits;
  assign initial_bits_out_o = res_q.init;
  assign waiters_out_o      = res_q.waiters;
  assign multi_out_o        = res_q.multi;
  assign option_out_o       = res_q.option;
  assign last_o             = res_q.last;

`ifndef SYNTHESIS
  // table fill never exceeds its depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= NUM_WAITERS)
    else $error("waiter fill above table depth");

  // compaction write pointer never passes the scan pointer
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> (w_q <= p_q && p_q <= fill_q))
    else $error("waiter compaction out of order");

  // a wakeup is never the closing reply
  a_wake_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.kind |-> !res_q.last)
    else $error("wakeup marked as last");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_event_flag_wait_set_unit.sv
// ----------------------------------------------------------------------------
// tb_event_flag_wait_set_unit
// Drives create/delete/set/clear/wait/poll/status commands with random idling
// on both channels, predicts every wakeup and reply with a behavioral model
// of the flag bank and waiter table, and compares each output transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_event_flag_wait_set_unit;
  import efw_pkg::*;

  localparam int unsigned NFLAG = 16;
  localparam int unsigned NWAIT = 16;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    cmd_e              command;
    logic [3:0]        flag_id;
    logic [FLAG_W-1:0] bits;
    logic              multi_attr;
    logic [FLAG_W-1:0] option_word;
    logic              wait_or;
    logic              wait_clear;
    logic [TID_W-1:0]  thread_id;
  } command_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] command_i = '0;
  logic [3:0] flag_id_i = '0;
  logic [FLAG_W-1:0] bits_i = '0;
  logic multi_attr_i = 1'b0;
  logic [FLAG_W-1:0] option_word_i = '0;
  logic wait_or_i = 1'b0;
  logic wait_clear_i = 1'b0;
  logic [TID_W-1:0] thread_id_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic kind_o;
  logic [3:0] status_o;
  logic [3:0] result_flag_o;
  logic [TID_W-1:0] woken_thread_o;
  logic [FLAG_W-1:0] bits_out_o;
  logic [FLAG_W-1:0] initial_bits_out_o;
  logic [4:0] waiters_out_o;
  logic multi_out_o;
  logic [FLAG_W-1:0] option_out_o;
  logic last_o;

  event_flag_wait_set_unit dut (.*);

  always #4 clk_i = ~clk_i;

  // shadow flag bank and waiter table
  logic              mdl_used    [NFLAG];
  logic [FLAG_W-1:0] mdl_pattern [NFLAG];
  logic [FLAG_W-1:0] mdl_initial [NFLAG];
  logic              mdl_multi   [NFLAG];
  logic [FLAG_W-1:0] mdl_option  [NFLAG];
  logic [4:0]        mdl_waiters [NFLAG];
  int unsigned       mdl_fill;
  logic [3:0]        row_flag    [NWAIT];
  logic [FLAG_W-1:0] row_pattern [NWAIT];
  logic              row_or      [NWAIT];
  logic              row_clear   [NWAIT];
  logic [TID_W-1:0]  row_thread  [NWAIT];

  command_t pending_cmds[$];
  result_t  expected_results[$];
  int unsigned mismatches = 0;
  int unsigned watchdog = 0;
  bit stim_done = 1'b0;

  function automatic logic pattern_hit(logic [FLAG_W-1:0] f, logic [FLAG_W-1:0] p, logic any);
    return any ? ((f & p) != '0) : ((f & p) == p);
  endfunction

  function automatic void push_result(logic kind, status_e st, logic [3:0] fl,
                                      logic [TID_W-1:0] th, logic [FLAG_W-1:0] b,
                                      logic last);
    result_t r;
    r = '0;
    r.kind = kind; r.status = st; r.flag = fl; r.thread = th; r.bits = b; r.last = last;
    expected_results.push_back(r);
  endfunction

  function automatic void remove_row(int unsigned i);
    for (int unsigned j = i; j + 1 < mdl_fill; j++) begin
      row_flag[j] = row_flag[j+1]; row_pattern[j] = row_pattern[j+1];
      row_or[j] = row_or[j+1]; row_clear[j] = row_clear[j+1];
      row_thread[j] = row_thread[j+1];
    end
    if (mdl_fill > 0) mdl_fill--;
  endfunction

  // expected results of one accepted command
  function automatic void predict_flag_op(command_t c);
    int unsigned i;
    logic [3:0] f;
    logic [FLAG_W-1:0] seen;
    result_t r;
    f = c.flag_id;
    if (c.command == CMD_CREATE) begin
      for (i = 0; i < NFLAG; i++) begin
        if (!mdl_used[i]) begin
          mdl_used[i] = 1'b1; mdl_pattern[i] = c.bits; mdl_initial[i] = c.bits;
          mdl_multi[i] = c.multi_attr; mdl_option[i] = c.option_word; mdl_waiters[i] = '0;
          push_result(1'b0, ST_OK, 4'(i), '0, '0, 1'b1);
          return;
        end
      end
      push_result(1'b0, ST_NO_SLOT, '0, '0, '0, 1'b1);
      return;
    end
    if (c.command == CMD_NONE) begin
      push_result(1'b0, ST_OK, '0, '0, '0, 1'b1);
      return;
    end
    if ((c.command == CMD_WAIT || c.command == CMD_POLL) && c.bits == '0) begin
      push_result(1'b0, ST_ZERO_PAT, f, '0, '0, 1'b1);
      return;
    end
    if (!mdl_used[f]) begin
      push_result(1'b0, ST_UNKNOWN, f, '0, '0, 1'b1);
      return;
    end
    case (c.command)
      CMD_DELETE: begin
        i = 0;
        while (i < mdl_fill) begin
          if (row_flag[i] == f) begin
            push_result(1'b1, ST_DELETED, f, row_thread[i], '0, 1'b0);
            remove_row(i);
          end else i++;
        end
        mdl_used[f] = 1'b0; mdl_waiters[f] = '0;
        push_result(1'b0, ST_OK, f, '0, '0, 1'b1);
      end
      CMD_SET: begin
        if (c.bits != '0) begin
          mdl_pattern[f] |= c.bits;
          i = 0;
          while (i < mdl_fill && mdl_pattern[f] != '0) begin
            if (row_flag[i] == f && pattern_hit(mdl_pattern[f], row_pattern[i], row_or[i])) begin
              push_result(1'b1, ST_OK, f, row_thread[i], mdl_pattern[f], 1'b0);
              if (row_clear[i]) mdl_pattern[f] = '0;
              if (mdl_waiters[f] > 0) mdl_waiters[f]--;
              remove_row(i);
            end else i++;
          end
        end
        push_result(1'b0, ST_OK, f, '0, '0, 1'b1);
      end
      CMD_CLEAR: begin
        mdl_pattern[f] &= c.bits;
        push_result(1'b0, ST_OK, f, '0, '0, 1'b1);
      end
      CMD_WAIT, CMD_POLL: begin
        if (!mdl_multi[f] && mdl_waiters[f] > 0)
          push_result(1'b0, ST_MULTI, f, '0, '0, 1'b1);
        else if (pattern_hit(mdl_pattern[f], c.bits, c.wait_or)) begin
          seen = mdl_pattern[f];
          if (c.wait_clear) mdl_pattern[f] = '0;
          push_result(1'b0, ST_OK, f, '0, seen, 1'b1);
        end else if (c.command == CMD_POLL)
          push_result(1'b0, ST_COND, f, '0, '0, 1'b1);
        else if (mdl_fill >= NWAIT)
          push_result(1'b0, ST_FULL, f, '0, '0, 1'b1);
        else begin
          row_flag[mdl_fill] = f; row_pattern[mdl_fill] = c.bits;
          row_or[mdl_fill] = c.wait_or; row_clear[mdl_fill] = c.wait_clear;
          row_thread[mdl_fill] = c.thread_id;
          mdl_fill++; mdl_waiters[f]++;
          push_result(1'b0, ST_QUEUED, f, '0, '0, 1'b1);
        end
      end
      default: begin
        r = '0;
        r.status = ST_OK; r.flag = f; r.bits = mdl_pattern[f]; r.init = mdl_initial[f];
        r.waiters = mdl_waiters[f]; r.multi = mdl_multi[f]; r.option = mdl_option[f];
        r.last = 1'b1;
        expected_results.push_back(r);
      end
    endcase
  endfunction

  function automatic command_t make_cmd(cmd_e op, logic [3:0] f, logic [FLAG_W-1:0] b);
    command_t c;
    c.command = op; c.flag_id = f; c.bits = b;
    c.multi_attr = 1'($urandom_range(1, 0)); c.option_word = $urandom;
    c.wait_or = 1'($urandom_range(1, 0)); c.wait_clear = 1'($urandom_range(1, 0));
    c.thread_id = TID_W'($urandom);
    return c;
  endfunction

  // random pattern: mostly few bits so matches happen, sometimes wide
  function automatic logic [FLAG_W-1:0] rand_bits();
    case ($urandom_range(5, 0))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return FLAG_W'($urandom_range(15, 1)) << $urandom_range(3, 0);
    endcase
  endfunction

  // stimulus
  initial begin
    command_t c;
    int unsigned pick;
    for (int i = 0; i < NFLAG; i++) mdl_used[i] = 1'b0;
    mdl_fill = 0;
    // directed: unknown ids, zero pattern, unused code
    pending_cmds.push_back(make_cmd(CMD_STATUS, 4'd15, '0));
    pending_cmds.push_back(make_cmd(CMD_WAIT, 4'd3, '0));
    pending_cmds.push_back(make_cmd(CMD_NONE, 4'd9, '1));
    // fill every slot then overflow
    for (int i = 0; i < 17; i++) begin
      c = make_cmd(CMD_CREATE, 4'(i), (i == 0) ? '1 : FLAG_W'(i));
      c.multi_attr = (i != 1);
      c.option_word = (i == 0) ? '1 : $urandom;
      pending_cmds.push_back(c);
    end
    // single waiter rule, set zero, poll fail, queue, wake, clear, delete
    c = make_cmd(CMD_WAIT, 4'd1, 32'h8000_0000); c.wait_or = 1'b0;
    c.thread_id = 8'hff; pending_cmds.push_back(c);
    pending_cmds.push_back(make_cmd(CMD_POLL, 4'd1, 32'h1));
    pending_cmds.push_back(make_cmd(CMD_SET, 4'd1, '0));
    c = make_cmd(CMD_POLL, 4'd2, 32'h4); c.wait_or = 1'b1; pending_cmds.push_back(c);
    pending_cmds.push_back(make_cmd(CMD_SET, 4'd1, 32'h8000_0000));
    pending_cmds.push_back(make_cmd(CMD_CLEAR, 4'd0, 32'h0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, 4'd0, '0));
    // random part: ops focused on few flags so waits and wakes interact
    for (int n = 0; n < 143; n++) begin
      pick = $urandom_range(99, 0);
      c = make_cmd(CMD_STATUS, 4'($urandom_range(5, 0)), rand_bits());
      if (pick < 10) c.command = CMD_CREATE;
      else if (pick < 16) c.command = CMD_DELETE;
      else if (pick < 38) c.command = CMD_SET;
      else if (pick < 46) c.command = CMD_CLEAR;
      else if (pick < 76) c.command = CMD_WAIT;
      else if (pick < 88) c.command = CMD_POLL;
      else if (pick < 97) c.command = CMD_STATUS;
      else c.command = CMD_NONE;
      if ($urandom_range(9, 0) == 0) c.flag_id = 4'($urandom);
      pending_cmds.push_back(c);
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    command_t c;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_flag_op({cmd_e'(command_i), flag_id_i, bits_i, multi_attr_i, option_word_i,
                         wait_or_i, wait_clear_i, thread_id_i});
        send_gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 0);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          command_i <= c.command; flag_id_i <= c.flag_id; bits_i <= c.bits;
          multi_attr_i <= c.multi_attr; option_word_i <= c.option_word;
          wait_or_i <= c.wait_or; wait_clear_i <= c.wait_clear; thread_id_i <= c.thread_id;
        end else begin
          in_valid_i <= 1'b0;
          stim_done = 1'b1;
        end
      end
    end
  end

  // monitor and stall generator
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    result_t exp_r;
    result_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {kind_o, status_e'(status_o), result_flag_o, woken_thread_o, bits_out_o,
               initial_bits_out_o, waiters_out_o, multi_out_o, option_out_o, last_o};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer: %p", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
          end
        end
        stall_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 0);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else out_stall_i <= 1'b0;
      // watchdog on cycles without any transfer
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) watchdog = 0;
      else watchdog++;
    end
  end

  // end of run
  initial begin
    wait (rst_ni);
    while (!(stim_done && expected_results.size() == 0) && watchdog < WATCHDOG_LIMIT)
      @(posedge clk_i);
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
    end else begin
      repeat (40) @(posedge clk_i);
      if (mismatches == 0 && expected_results.size() == 0) begin
        $display("DONE: 0 errors");
      end else begin
        $display("DONE: errors detected");
      end
    end
    $finish;
  end

endmodule

FILE: event_flag_wait_set_unit.f
rtl/efw_pkg.sv
rtl/event_flag_wait_set_unit.sv
tb/sv/tb_event_flag_wait_set_unit.sv
